FILE: hdl/drd_pkg.sv
// Shared types and constants for the delimited record deframer.
// Used by drd_ctrl, drd_datapath and delimited_record_deframer; depends on nothing.
`default_nettype none

package drd_pkg;

    localparam int MAX_RECORD = 64;
    localparam int ADDR_W     = $clog2(MAX_RECORD);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] CONTINUE_RESET = 8'd10;
    localparam logic [7:0] END_RESET      = 8'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd1;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic store_byte;
        logic set_ovf;
        logic load_single;
        logic start_read;
        logic load_byte;
        logic clear_record;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_term;
        logic rec_empty;
        logic ovf;
        logic full;
        logic rd_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: hdl/drd_ctrl.sv
// Controller state machine of the deframer: accepts bytes and sequences readout.
// Depends on drd_pkg.
`default_nettype none

module drd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire drd_pkg::sts_t sts,
    output drd_pkg::cmd_t      cmd
);
    import drd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.is_term && !sts.ovf && !sts.rec_empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.out_free && sts.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_term)
                    begin
                        if (sts.ovf || sts.rec_empty)
                        begin
                            cmd.load_single  = 1'b1;
                            cmd.clear_record = 1'b1;
                        end
                        else
                        begin
                            cmd.start_read = 1'b1;
                        end
                    end
                    else if (!sts.ovf)
                    begin
                        cmd.store_byte = !sts.full;
                        cmd.set_ovf    = sts.full;
                    end
                end
            end
            ST_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte    = 1'b1;
                    cmd.clear_record = sts.rd_last;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/drd_datapath.sv
// Datapath of the deframer: terminator registers, record store, count and result register.
// Depends on drd_pkg; driven by drd_ctrl.
`default_nettype none

module drd_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [drd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic [7:0]                      rx_byte,
    input  wire drd_pkg::cmd_t                   cmd,
    output drd_pkg::sts_t                        sts,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           kind,
    output logic [7:0]                           data_byte,
    output logic                                 is_final,
    output logic                                 last
);
    import drd_pkg::*;

    logic [7:0]        cont_reg;
    logic [7:0]        end_reg;
    logic [7:0]        mem [MAX_RECORD];
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic              fin_reg;
    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [7:0]        data_reg;
    logic              final_reg;
    logic              last_reg;
    logic              rx_fin;
    logic              loading;

    assign rx_fin  = (rx_byte == end_reg);
    assign loading = cmd.load_single || cmd.load_byte;

    assign sts.is_term   = (rx_byte == cont_reg) || rx_fin;
    assign sts.rec_empty = (count_reg == '0);
    assign sts.ovf       = ovf_reg;
    assign sts.full      = (count_reg >= CNT_W'(MAX_RECORD));
    assign sts.rd_last   = ({1'b0, rd_ptr_reg} == (count_reg - CNT_W'(1)));
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg <= CONTINUE_RESET;
            end_reg  <= END_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONTINUE: cont_reg <= cfg_data;
                CFG_END:      end_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_record)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.store_byte)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (loading)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Record store; the read port doubles as the data byte of the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.load_byte)
        begin
            data_reg <= mem[rd_ptr_reg];
        end
        else if (cmd.load_single)
        begin
            data_reg <= 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_read)
        begin
            rd_ptr_reg <= '0;
            fin_reg    <= rx_fin;
        end
        else if (cmd.load_byte)
        begin
            rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
        end
        if (cmd.load_single)
        begin
            kind_reg  <= ovf_reg ? KIND_OVERFLOW : KIND_EMPTY;
            final_reg <= rx_fin;
            last_reg  <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            kind_reg  <= KIND_BYTE;
            final_reg <= fin_reg;
            last_reg  <= sts.rd_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign is_final  = final_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: hdl/delimited_record_deframer.sv
// Top level of the delimited record deframer: joins controller and datapath.
// Depends on drd_pkg, drd_ctrl and drd_datapath.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    rx_byte
//   out      source     out_valid / out_ready  kind, data_byte, is_final, last
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input request is taken whenever no readout is in progress and the result
// register is free or being drained in that cycle. A terminator of a non-empty
// record without overflow holds input off while the store is read out, one byte
// per cycle through the single read port when the output does not stall.
// Reset clears the count, the overflow flag and the result valid flag and sets
// the terminators to 10 and 13; the record store itself is not cleared.
`default_nettype none

module delimited_record_deframer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          kind,
    output logic [7:0]                          data_byte,
    output logic                                is_final,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [drd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                     cfg_data
);
    import drd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    drd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    drd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .is_final  (is_final),
        .last      (last)
    );

    // An empty or discarded record shows up as a single result with last set.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_single |=> out_valid && last && (kind != KIND_BYTE))
        else $error("single result not presented");

    // Results other than record bytes carry a zero data byte and close the request.
    a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_BYTE)) |-> (data_byte == 8'd0) && last)
        else $error("non-byte result with data or without last");

    // The final byte of a readout is flagged last and no input is taken meanwhile.
    a_readout_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_byte && sts.rd_last) |=> out_valid && last && (kind == KIND_BYTE))
        else $error("readout did not end with last");

    a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_byte |-> !in_ready)
        else $error("input taken during readout");

endmodule

`default_nettype wire
